>>> rtl/step_dir_position_follower_defines.svh
// assertion macros for the step/direction position follower
`ifndef STEP_DIR_POSITION_FOLLOWER_DEFINES_SVH
`define STEP_DIR_POSITION_FOLLOWER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define SDPF_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdpf assertion failed");
// next-cycle implication, disabled during reset
`define SDPF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdpf assertion failed");
`else
`define SDPF_ASSERT(label, ante, cons)
`define SDPF_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/sdpf_pkg.sv
package sdpf_pkg;

	// default position counter width
	localparam int unsigned POSITION_WIDTH_DEF = 32;

	// configuration reset values and limits
	localparam logic [15:0] HALF_PERIOD_RST  = 16'd26;
	localparam logic [7:0]  DEBOUNCE_THR_RST = 8'd128;
	localparam logic [7:0]  DEBOUNCE_MAX     = 8'd254;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_HALF_PERIOD  = 2'd0,
		REG_DEBOUNCE_THR = 2'd1
	} cfg_reg_t;

	// request commands
	typedef enum logic [2:0] {
		CMD_NONE      = 3'd0,
		CMD_INC       = 3'd1,
		CMD_DEC       = 3'd2,
		CMD_ADD       = 3'd3,
		CMD_SUB       = 3'd4,
		CMD_SET       = 3'd5,
		CMD_ZERO_TGT  = 3'd6,
		CMD_ZERO_ALL  = 3'd7
	} cmd_t;

	// debounced step event toward the target
	typedef struct packed {
		logic step;
		logic fwd;
	} dbnc_evt_t;

endpackage

>>> rtl/step_dir_position_follower.sv
// step/direction position follower
// a result is registered and presented in the cycle after its request is accepted
// throughput: one request per cycle; the single output register stalls input
// only while a result waits and the output side stalls
// reset: position, target, timer and debounce count clear; half period 26, threshold 128
`include "step_dir_position_follower_defines.svh"

module step_dir_position_follower #(
	parameter int unsigned POSITION_WIDTH = sdpf_pkg::POSITION_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	input  logic               step_in,
	input  logic               dir_in,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               step_out,
	output logic               dir_out,
	output logic signed [31:0] position,
	output logic signed [31:0] target,
	output logic               moving
);
	import sdpf_pkg::*;

	localparam int unsigned PW = POSITION_WIDTH;

	logic [15:0]   hp_q;
	logic [7:0]    thr_q;
	logic [PW-1:0] pos_q, tgt_q;
	logic [15:0]   tick_q;
	logic          run_q, step_q, dir_q;

	logic          acc;
	dbnc_evt_t     evt;
	logic [PW-1:0] value_w;
	logic [16:0]   tick_inc;
	logic          tmr_hit;
	logic [15:0]   tick_t, tick_n;
	logic          run_t, run_n, step_t, dir_t, start;
	logic [PW-1:0] pos_t, pos_n, tgt_n, dbn_delta, cmd_op;

	// handshake
	assign in_stall = out_valid && out_stall;
	assign acc      = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q  <= HALF_PERIOD_RST;
			thr_q <= DEBOUNCE_THR_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HALF_PERIOD:  hp_q  <= cfg_data;
				REG_DEBOUNCE_THR: thr_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// step input debounce
	sdpf_debounce u_dbnc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (acc),
		.step_in (step_in),
		.dir_in  (dir_in),
		.thr     (thr_q),
		.evt     (evt)
	);

	assign value_w = PW'(value);

	// half-period timer and step toggle
	always_comb begin
		tick_inc = {1'b0, tick_q} + 17'd1;
		tmr_hit  = run_q && (tick_inc >= {1'b0, hp_q});
		tick_t   = run_q ? (tmr_hit ? 16'd0 : tick_inc[15:0]) : tick_q;
		run_t    = run_q;
		step_t   = step_q;
		dir_t    = dir_q;
		pos_t    = pos_q;
		if (tmr_hit) begin
			if (step_q) begin
				// falling edge: pick direction or stop
				if ($signed(tgt_q) > $signed(pos_q)) begin
					dir_t = 1'b1;
				end else if ($signed(tgt_q) < $signed(pos_q)) begin
					dir_t = 1'b0;
				end else begin
					run_t = 1'b0;
				end
				step_t = 1'b0;
			end else begin
				// rising edge: move position
				step_t = 1'b1;
				pos_t  = dir_q ? pos_q + PW'(1) : pos_q - PW'(1);
			end
		end
	end

	// target update from debounced step and command
	always_comb begin
		dbn_delta = '0;
		if (evt.step) begin
			dbn_delta = evt.fwd ? PW'(1) : {PW{1'b1}};
		end
		cmd_op = '0;
		pos_n  = pos_t;
		tgt_n  = '0;
		unique case (cmd_t'(command))
			CMD_INC:      cmd_op = PW'(1);
			CMD_DEC:      cmd_op = {PW{1'b1}};
			CMD_ADD:      cmd_op = value_w;
			CMD_SUB:      cmd_op = -value_w;
			CMD_NONE, CMD_SET, CMD_ZERO_TGT, CMD_ZERO_ALL: cmd_op = '0;
		endcase
		unique case (cmd_t'(command))
			CMD_SET:      tgt_n = value_w;
			CMD_ZERO_TGT: tgt_n = '0;
			CMD_ZERO_ALL: begin
				tgt_n = '0;
				pos_n = '0;
			end
			CMD_NONE, CMD_INC, CMD_DEC, CMD_ADD, CMD_SUB:
				tgt_n = tgt_q + dbn_delta + cmd_op;
		endcase
		// start the timer when there is distance to cover
		start  = (tgt_n != pos_n) && !run_t;
		run_n  = run_t || start;
		tick_n = start ? 16'd0 : tick_t;
	end

	// follower state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tgt_q  <= '0;
			tick_q <= 16'd0;
			run_q  <= 1'b0;
			step_q <= 1'b0;
			dir_q  <= 1'b0;
		end else if (acc) begin
			pos_q  <= pos_n;
			tgt_q  <= tgt_n;
			tick_q <= tick_n;
			run_q  <= run_n;
			step_q <= step_t;
			dir_q  <= dir_t;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (acc) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			step_out <= step_t;
			dir_out  <= dir_t;
			position <= 32'(pos_n);
			target   <= 32'(tgt_n);
			moving   <= run_n;
		end
	end

	// a stopped timer means the position has reached the target
	`SDPF_ASSERT(a_stop_at_target, !run_q, tgt_q == pos_q)
	// the timer only stops on a falling step edge
	`SDPF_ASSERT(a_stop_on_fall, $fell(run_q), !step_q)
	// an accepted request always leaves a result behind
	`SDPF_ASSERT_NXT(a_acc_result, acc, out_valid)

endmodule

>>> rtl/sdpf_debounce.sv
module sdpf_debounce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                step_in,
	input  logic                dir_in,
	input  logic [7:0]          thr,
	output sdpf_pkg::dbnc_evt_t evt
);
	import sdpf_pkg::*;

	logic [7:0] cnt_q;
	logic [7:0] cnt_n;
	logic [7:0] thr_c;

	// clamp so the counter never wraps
	assign thr_c = (thr > DEBOUNCE_MAX) ? DEBOUNCE_MAX : thr;

	// count consecutive low samples, fire once at the threshold
	always_comb begin
		cnt_n    = cnt_q;
		evt.step = 1'b0;
		evt.fwd  = dir_in;
		if (!step_in) begin
			if (cnt_q == thr_c) begin
				evt.step = 1'b1;
				cnt_n    = cnt_q + 8'd1;
			end else if (cnt_q < thr_c) begin
				cnt_n = cnt_q + 8'd1;
			end
		end else begin
			cnt_n = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 8'd0;
		end else if (en) begin
			cnt_q <= cnt_n;
		end
	end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import sdpf_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int DRAIN_CYCLES    = 4;
	// index with no register behind it, writes must be ignored
	localparam logic [1:0] REG_UNUSED_IDX = 2'd3;

	// one expected result
	typedef struct packed {
		logic        step;
		logic        dir;
		logic [31:0] pos;
		logic [31:0] tgt;
		logic        running;
	} motion_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [2:0] command;
	logic signed [31:0] value;
	logic step_in;
	logic dir_in;
	logic out_valid;
	logic out_stall;
	logic step_out;
	logic dir_out;
	logic signed [31:0] position;
	logic signed [31:0] target;
	logic moving;

	// follower state mirrored from the accepted requests
	logic [31:0] trk_pos;
	logic [31:0] trk_tgt;
	logic [7:0]  trk_dbnc;
	logic [15:0] trk_ticks;
	logic        trk_running;
	logic        trk_step;
	logic        trk_dir;
	logic [15:0] trk_half;
	logic [7:0]  trk_threshold;

	motion_t motion_q[$];
	int errors = 0;
	bit full_speed = 1'b0;
	bit hold_off_req = 1'b0;

	step_dir_position_follower DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.value     (value),
		.step_in   (step_in),
		.dir_in    (dir_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.step_out  (step_out),
		.dir_out   (dir_out),
		.position  (position),
		.target    (target),
		.moving    (moving)
	);

	always #5 clk = ~clk;

	// advance the follower by one tick and return what the block should show
	function automatic motion_t step_motion(cmd_t cmd, logic [31:0] val, logic step_lvl,
			logic pin_dir);
		logic [16:0] nxt;
		logic [7:0] thr;
		motion_t m;
		// step timer, toggles the output at the half period
		if (trk_running) begin
			nxt = {1'b0, trk_ticks} + 17'd1;
			if (nxt >= {1'b0, trk_half}) begin
				trk_ticks = '0;
				if (trk_step) begin
					if ($signed(trk_tgt) > $signed(trk_pos))
						trk_dir = 1'b1;
					else if ($signed(trk_tgt) < $signed(trk_pos))
						trk_dir = 1'b0;
					else
						trk_running = 1'b0;
					trk_step = 1'b0;
				end else begin
					trk_step = 1'b1;
					trk_pos = trk_dir ? trk_pos + 32'd1 : trk_pos - 32'd1;
				end
			end else begin
				trk_ticks = nxt[15:0];
			end
		end
		// debounce of the active-low step pin
		thr = (trk_threshold > DEBOUNCE_MAX) ? DEBOUNCE_MAX : trk_threshold;
		if (!step_lvl) begin
			if (trk_dbnc >= thr) begin
				if (trk_dbnc == thr) begin
					trk_tgt = pin_dir ? trk_tgt + 32'd1 : trk_tgt - 32'd1;
					trk_dbnc = trk_dbnc + 8'd1;
				end
			end else begin
				trk_dbnc = trk_dbnc + 8'd1;
			end
		end else begin
			trk_dbnc = '0;
		end
		// command
		case (cmd)
			CMD_INC:      trk_tgt = trk_tgt + 32'd1;
			CMD_DEC:      trk_tgt = trk_tgt - 32'd1;
			CMD_ADD:      trk_tgt = trk_tgt + val;
			CMD_SUB:      trk_tgt = trk_tgt - val;
			CMD_SET:      trk_tgt = val;
			CMD_ZERO_TGT: trk_tgt = '0;
			CMD_ZERO_ALL: begin
				trk_tgt = '0;
				trk_pos = '0;
			end
			default: ;
		endcase
		// start the timer when there is somewhere to go
		if (trk_tgt != trk_pos && !trk_running) begin
			trk_ticks = '0;
			trk_running = 1'b1;
		end
		m.step = trk_step;
		m.dir = trk_dir;
		m.pos = trk_pos;
		m.tgt = trk_tgt;
		m.running = trk_running;
		return m;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 'h%h, got 'h%h", name, want, got);
			errors++;
		end
	endfunction

	// offer one request and hold it until the block takes it
	task automatic send_request(cmd_t cmd, logic [31:0] val, logic step_lvl, logic pin_dir);
		in_valid <= 1'b1;
		command <= cmd;
		value <= val;
		step_in <= step_lvl;
		dir_in <= pin_dir;
		do @(posedge clk); while (in_stall);
		motion_q.push_back(step_motion(cmd, val, step_lvl, pin_dir));
	endtask

	task automatic pause_sender();
		if (!full_speed && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// let every outstanding result come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (motion_q.size() != 0) @(posedge clk);
	endtask

	// write both registers and the unused index while nothing is in flight
	task automatic configure(logic [15:0] hp, logic [7:0] thr);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= REG_HALF_PERIOD;
		cfg_data <= hp;
		@(posedge clk);
		trk_half = hp;
		cfg_index <= REG_DEBOUNCE_THR;
		cfg_data <= {8'($urandom), thr};
		@(posedge clk);
		trk_threshold = thr;
		cfg_index <= REG_UNUSED_IDX;
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// every command at the reset settings, with value extremes and wrap
	task automatic test_commands();
		send_request(CMD_INC, 32'($urandom), 1'b1, 1'b0);
		send_request(CMD_DEC, 32'($urandom), 1'b1, 1'b1);
		send_request(CMD_ADD, 32'h7FFF_FFFF, 1'b1, 1'b0);
		pause_sender();
		send_request(CMD_ADD, 32'h0000_0001, 1'b1, 1'b1);
		send_request(CMD_SUB, 32'h8000_0000, 1'b1, 1'b0);
		send_request(CMD_SET, 32'hFFFF_FFFF, 1'b1, 1'b1);
		pause_sender();
		send_request(CMD_NONE, 32'($urandom), 1'b1, 1'b0);
		send_request(CMD_ZERO_TGT, 32'($urandom), 1'b1, 1'b1);
		send_request(CMD_SET, 32'd3, 1'b1, 1'b0);
		send_request(CMD_ZERO_ALL, 32'($urandom), 1'b1, 1'b1);
	endtask

	// zero half period toggles every tick, zero threshold fires on the first low sample
	task automatic test_zero_settings();
		configure(16'd0, 8'd0);
		send_request(CMD_NONE, 32'd0, 1'b0, 1'b1);
		send_request(CMD_NONE, 32'd0, 1'b0, 1'b0);
		send_request(CMD_NONE, 32'd0, 1'b1, 1'b0);
		send_request(CMD_NONE, 32'd0, 1'b0, 1'b0);
	endtask

	// half period cut below the running tick count toggles on the next tick
	task automatic test_half_period_cut();
		configure(16'hFFFF, DEBOUNCE_THR_RST);
		send_request(CMD_SET, 32'd3, 1'b1, 1'b0);
		repeat (3) send_request(CMD_NONE, 32'd0, 1'b1, 1'b1);
		configure(16'd2, DEBOUNCE_THR_RST);
		send_request(CMD_NONE, 32'd0, 1'b1, 1'b0);
	endtask

	// threshold cut below the count holds the count until the pin goes high
	task automatic test_threshold_cut();
		configure(16'd1, 8'd8);
		repeat (5) send_request(CMD_NONE, 32'd0, 1'b0, 1'b1);
		configure(16'd1, 8'd2);
		repeat (2) send_request(CMD_NONE, 32'd0, 1'b0, 1'b1);
		send_request(CMD_NONE, 32'd0, 1'b1, 1'b1);
	endtask

	// step pulses around the threshold with sparse commands, a few broken pulses
	task automatic run_phase(logic [15:0] hp, logic [7:0] thr, int n, bit squeeze);
		int run_left;
		int thr_eff;
		bit pin_low;
		bit pin_dir;
		cmd_t cmd;
		logic [31:0] val;
		configure(hp, thr);
		thr_eff = int'((thr > DEBOUNCE_MAX) ? DEBOUNCE_MAX : thr);
		run_left = 0;
		pin_low = 1'b0;
		pin_dir = 1'b0;
		full_speed = squeeze;
		hold_off_req = squeeze;
		for (int i = 0; i < n; i++) begin
			if (!squeeze && i % 40 == 0)
				full_speed = ($urandom_range(0, 3) == 0);
			if (run_left == 0) begin
				pin_low = !pin_low;
				pin_dir = 1'($urandom_range(0, 1));
				if (!pin_low)
					run_left = $urandom_range(1, 4);
				else if ($urandom_range(0, 4) == 0)
					run_left = $urandom_range(1, thr_eff + 1);
				else
					run_left = thr_eff + $urandom_range(1, 3);
			end
			run_left--;
			cmd = CMD_NONE;
			if ($urandom_range(0, 6) == 0)
				cmd = cmd_t'(3'($urandom_range(1, 7)));
			if ($urandom_range(0, 2) == 0)
				val = $urandom;
			else
				val = 32'($urandom_range(0, 40)) - 32'd20;
			send_request(cmd, val, !pin_low, ($urandom_range(0, 9) == 0) ? !pin_dir : pin_dir);
			pause_sender();
		end
		full_speed = 1'b0;
	endtask

	// receiver: random stalls, and a long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (full_speed || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				repeat (gap_len()) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin : check_results
		motion_t m;
		if (arst_n && out_valid && !out_stall) begin
			if (motion_q.size() == 0) begin
				$error("result with no request pending");
				errors++;
			end else begin
				m = motion_q.pop_front();
				check_field("step_out", 32'(m.step), 32'(step_out));
				check_field("dir_out", 32'(m.dir), 32'(dir_out));
				check_field("position", m.pos, position);
				check_field("target", m.tgt, target);
				check_field("moving", 32'(m.running), 32'(moving));
			end
		end
	end

	// end the run if nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL step_dir_position_follower");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_HALF_PERIOD;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_NONE;
		value = '0;
		step_in = 1'b1;
		dir_in = 1'b0;
		trk_pos = '0;
		trk_tgt = '0;
		trk_dbnc = '0;
		trk_ticks = '0;
		trk_running = 1'b0;
		trk_step = 1'b0;
		trk_dir = 1'b0;
		trk_half = HALF_PERIOD_RST;
		trk_threshold = DEBOUNCE_THR_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_zero_settings();
		test_half_period_cut();
		test_threshold_cut();
		run_phase(16'd2, 8'd4, 30, 1'b1);
		run_phase(16'd1, 8'd1, 110, 1'b0);
		run_phase(16'd2, 8'd3, 90, 1'b0);
		run_phase(16'd3, 8'd0, 70, 1'b0);
		run_phase(16'd0, 8'd2, 50, 1'b0);
		run_phase(16'd4, 8'hFF, 270, 1'b0);
		run_phase(16'hFFFF, DEBOUNCE_MAX, 20, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS step_dir_position_follower");
		else
			$display("FAIL step_dir_position_follower");
		$finish;
	end

endmodule
